FILE: rtl/edsmp_pkg.sv
// Shared types and constants for the random edge dedup sampler.
// Request structs, configuration register indexes and controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package edsmp_pkg;

    // Field widths
    localparam int DRAW_W     = 31;
    localparam int VERTEX_W   = 16;
    localparam int EDGE_CNT_W = 11;
    localparam int INDEX_W    = 10;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int ENTRY_W    = 2 * VERTEX_W;
    localparam int DIV_STEPS  = DRAW_W;

    // Register reset values
    localparam logic [VERTEX_W-1:0]   VERTEX_COUNT_RST = 16'd16;
    localparam logic [EDGE_CNT_W-1:0] EDGE_COUNT_RST   = 11'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT   = 1'b1;

    // Input request: two raw draws
    typedef struct packed {
        logic [DRAW_W-1:0] draw_first;
        logic [DRAW_W-1:0] draw_second;
    } t_in_req;

    // Output request: one accepted edge
    typedef struct packed {
        logic [INDEX_W-1:0]  edge_index;
        logic [VERTEX_W-1:0] vertex_u;
        logic [VERTEX_W-1:0] vertex_v;
        logic                last_edge;
    } t_out_req;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/edsmp_rem.sv
// Bit-serial restoring remainder unit: draw modulo vertex count.
// One quotient bit per cycle, one for each of the DIV_STEPS dividend bits.
// Depends on edsmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edsmp_rem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [edsmp_pkg::DRAW_W-1:0]   i_dividend,
    input  wire logic [edsmp_pkg::VERTEX_W-1:0] i_divisor,
    output logic                               o_done,
    output logic [edsmp_pkg::VERTEX_W-1:0]      o_rem
);

    localparam int STEP_W = $clog2(edsmp_pkg::DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(edsmp_pkg::DIV_STEPS - 1);

    logic [edsmp_pkg::DRAW_W-1:0]   r_dvd;
    logic [edsmp_pkg::VERTEX_W-1:0] r_div;
    logic [edsmp_pkg::VERTEX_W-1:0] r_rem;
    logic [STEP_W-1:0]              r_step;
    logic                           r_busy;
    logic                           r_done;

    logic [edsmp_pkg::VERTEX_W:0]   w_trial;
    logic [edsmp_pkg::VERTEX_W:0]   w_diff;
    logic [edsmp_pkg::VERTEX_W-1:0] n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[edsmp_pkg::DRAW_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[edsmp_pkg::VERTEX_W-1:0];
        end else begin
            n_rem = w_trial[edsmp_pkg::VERTEX_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[edsmp_pkg::DRAW_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/edsmp_mem.sv
// Edge store: single write port, single read port, registered read data.
// Each entry holds the two endpoints of one accepted edge.
// Depends on edsmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edsmp_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [edsmp_pkg::ENTRY_W-1:0] i_wdata,
    input  wire logic                          i_re,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic [edsmp_pkg::ENTRY_W-1:0]      o_rdata
);

    logic [edsmp_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [edsmp_pkg::ENTRY_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/random_edge_dedup_sampler.sv
// Random edge sampler with duplicate rejection: top level and controller.
// Uses edsmp_pkg, edsmp_rem (two instances) and edsmp_mem.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request
//   with two raw draws. Each draw is reduced modulo vertex_count, plus one.
//   Self loops and edges already in the current graph (either orientation)
//   are dropped with no output. An accepted edge goes out on the output
//   channel (o_out_valid / i_out_stall / o_out_data) with its index and a
//   last flag; after the last edge the next graph starts empty.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 = vertex_count, 1 = edge_count); write only while the block is idle.
// Flow: the two serial remainder units reduce the draws, the scan reads the
//   edge store once per stored edge and compares, then the edge is emitted.
//   Requests: one at a time, the next taken in the cycle after the emit;
//   a self loop frees the input as soon as the remainders are done.
// Reset: synchronous, active low; clears the edge count, sets both config
//   registers to 16. The edge store needs no clearing.
// Stall: the output register holds its request while i_out_stall is high;
//   the next request may be processed meanwhile and waits only to emit.
`timescale 1ns / 1ps
`default_nettype none

module random_edge_dedup_sampler #(
    parameter int MAX_EDGES = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire edsmp_pkg::t_in_req               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output edsmp_pkg::t_out_req                   o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [edsmp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [edsmp_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int TW    = ((CNT_W > edsmp_pkg::EDGE_CNT_W) ? CNT_W
                            : edsmp_pkg::EDGE_CNT_W) + 1;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_EDGES);
    localparam int VW    = edsmp_pkg::VERTEX_W;

    edsmp_pkg::t_state r_state;
    edsmp_pkg::t_state n_state;

    logic [VW-1:0]                    r_vertex_count;
    logic [edsmp_pkg::EDGE_CNT_W-1:0] r_edge_count;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 r_issue_cnt;
    logic                             r_cmp_pending;
    logic [VW-1:0]                    r_u;
    logic [VW-1:0]                    r_v;
    logic                             r_out_valid;
    edsmp_pkg::t_out_req              r_out;

    logic                             w_in_acc;
    logic [VW-1:0]                    w_divisor;
    logic                             w_done_a;
    logic                             w_done_b;
    logic [VW-1:0]                    w_rem_a;
    logic [VW-1:0]                    w_rem_b;
    logic                             w_rd_en;
    logic [edsmp_pkg::ENTRY_W-1:0]    w_rd_data;
    logic [VW-1:0]                    w_rd_u;
    logic [VW-1:0]                    w_rd_v;
    logic                             w_match;
    logic                             w_load;
    logic [TW-1:0]                    w_target;
    logic [TW-1:0]                    w_idx_ext;
    logic [TW-1:0]                    w_next_ext;
    logic                             w_last;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != edsmp_pkg::ST_IDLE);

    // Vertex count zero behaves as one
    assign w_divisor = (r_vertex_count == '0) ? VW'(1) : r_vertex_count;

    // Remainder units, one per draw
    edsmp_rem u_rem_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_dividend (i_in_data.draw_first),
        .i_divisor  (w_divisor),
        .o_done     (w_done_a),
        .o_rem      (w_rem_a)
    );

    edsmp_rem u_rem_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_dividend (i_in_data.draw_second),
        .i_divisor  (w_divisor),
        .o_done     (w_done_b),
        .o_rem      (w_rem_b)
    );

    // Edge store
    edsmp_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_u, r_v}),
        .i_re    (w_rd_en),
        .i_raddr (r_issue_cnt[AW-1:0]),
        .o_rdata (w_rd_data)
    );

    // Scan: one read per stored edge, compare on the returned data
    assign w_rd_en = (r_state == edsmp_pkg::ST_SCAN) && (r_issue_cnt < r_count);
    assign w_rd_u  = w_rd_data[edsmp_pkg::ENTRY_W-1:VW];
    assign w_rd_v  = w_rd_data[VW-1:0];
    assign w_match = r_cmp_pending &&
                     (((w_rd_u == r_u) && (w_rd_v == r_v)) ||
                      ((w_rd_u == r_v) && (w_rd_v == r_u)));

    // Effective target: edge count clamped to [1, MAX_EDGES]
    always_comb begin
        w_target = TW'(r_edge_count);
        if (r_edge_count == '0) begin
            w_target = TW'(1);
        end
        if (w_target > MAX_T) begin
            w_target = MAX_T;
        end
    end

    assign w_idx_ext  = TW'(r_count);
    assign w_next_ext = w_idx_ext + TW'(1);
    assign w_last     = (w_next_ext >= w_target);
    assign w_load     = (r_state == edsmp_pkg::ST_EMIT) && (!r_out_valid || !i_out_stall);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            edsmp_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = edsmp_pkg::ST_DIV;
                end
            end
            edsmp_pkg::ST_DIV: begin
                if (w_done_a && w_done_b) begin
                    // equal remainders mean a self loop
                    n_state = (w_rem_a == w_rem_b) ? edsmp_pkg::ST_IDLE
                                                   : edsmp_pkg::ST_SCAN;
                end
            end
            edsmp_pkg::ST_SCAN: begin
                if (w_match) begin
                    n_state = edsmp_pkg::ST_IDLE;
                end else if (!w_rd_en && !r_cmp_pending) begin
                    n_state = edsmp_pkg::ST_EMIT;
                end
            end
            edsmp_pkg::ST_EMIT: begin
                if (w_load) begin
                    n_state = edsmp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = edsmp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= edsmp_pkg::ST_IDLE;
            r_vertex_count <= edsmp_pkg::VERTEX_COUNT_RST;
            r_edge_count   <= edsmp_pkg::EDGE_COUNT_RST;
            r_count        <= '0;
            r_issue_cnt    <= '0;
            r_cmp_pending  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    edsmp_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                    edsmp_pkg::CFG_EDGE_COUNT:
                        r_edge_count <= i_cfg_data[edsmp_pkg::EDGE_CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == edsmp_pkg::ST_DIV) begin
                r_issue_cnt   <= '0;
                r_cmp_pending <= 1'b0;
            end else if (r_state == edsmp_pkg::ST_SCAN) begin
                if (w_rd_en) begin
                    r_issue_cnt <= r_issue_cnt + 1'b1;
                end
                r_cmp_pending <= w_rd_en && !w_match;
            end else begin
                r_cmp_pending <= 1'b0;
            end
            if (w_load) begin
                r_count     <= w_last ? '0 : w_next_ext[CNT_W-1:0];
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Candidate endpoints and output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == edsmp_pkg::ST_DIV) && w_done_a && w_done_b) begin
            r_u <= w_rem_a + VW'(1);
            r_v <= w_rem_b + VW'(1);
        end
        if (w_load) begin
            r_out.edge_index <= w_idx_ext[edsmp_pkg::INDEX_W-1:0];
            r_out.vertex_u   <= r_u;
            r_out.vertex_v   <= r_v;
            r_out.last_edge  <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The edge count always stays below the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TW'(r_count) < MAX_T)
        else $error("accepted edge count out of range");

    // Only written entries are read
    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_issue_cnt < r_count))
        else $error("edge store read beyond accepted edges");

    // A completed graph restarts from index zero
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_count == '0))
        else $error("edge count not cleared after last edge");

    // Emitted edges are never self loops
    a_no_self_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.vertex_u != o_out_data.vertex_v))
        else $error("self loop emitted");

    // An emit loads the output register with the edge at its index
    a_store_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && (o_out_data.edge_index ==
                    $past(w_idx_ext[edsmp_pkg::INDEX_W-1:0]))))
        else $error("output not loaded on emit");
`endif

endmodule

`default_nettype wire
